// File: rtl/core/morse_beacon_keyer_assert.svh
// Assertion macros shared by the keyer checks.
`ifndef MORSE_BEACON_KEYER_ASSERT_SVH
`define MORSE_BEACON_KEYER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MBK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyer check failed");

// Next-cycle implication, disabled while reset is low.
`define MBK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyer check failed");

`endif

// File: rtl/core/mbk_pkg.sv
package mbk_pkg;

    localparam int STORE_DEPTH = 128;
    localparam int AW          = $clog2(STORE_DEPTH);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_SOS   = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       transmit_enable;
        logic [6:0] store_index;
        logic [7:0] char_code;
    } t_in_beat;

    typedef struct packed {
        logic       dot_lamp;
        logic       dash_lamp;
        logic       sos_lamp;
        logic       sos_active;
        logic [6:0] read_position;
    } t_out_beat;

    // Store write port.
    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [7:0]    data;
    } t_store_wr;

    // Morse pattern: bit i set means element i is a dash.
    typedef struct packed {
        logic       known;
        logic [4:0] bits;
        logic [2:0] len;
    } t_pattern;

    function automatic t_pattern letter_pattern(input logic [4:0] idx);
        t_pattern p;
        p.known = 1'b1;
        case (idx)
            5'd0:    begin p.bits = 5'b00010; p.len = 3'd2; end // A
            5'd1:    begin p.bits = 5'b00001; p.len = 3'd4; end // B
            5'd2:    begin p.bits = 5'b00101; p.len = 3'd4; end // C
            5'd3:    begin p.bits = 5'b00001; p.len = 3'd3; end // D
            5'd4:    begin p.bits = 5'b00000; p.len = 3'd1; end // E
            5'd5:    begin p.bits = 5'b00100; p.len = 3'd4; end // F
            5'd6:    begin p.bits = 5'b00011; p.len = 3'd3; end // G
            5'd7:    begin p.bits = 5'b00000; p.len = 3'd4; end // H
            5'd8:    begin p.bits = 5'b00000; p.len = 3'd2; end // I
            5'd9:    begin p.bits = 5'b01110; p.len = 3'd4; end // J
            5'd10:   begin p.bits = 5'b00101; p.len = 3'd3; end // K
            5'd11:   begin p.bits = 5'b00010; p.len = 3'd4; end // L
            5'd12:   begin p.bits = 5'b00011; p.len = 3'd2; end // M
            5'd13:   begin p.bits = 5'b00001; p.len = 3'd2; end // N
            5'd14:   begin p.bits = 5'b00111; p.len = 3'd3; end // O
            5'd15:   begin p.bits = 5'b00110; p.len = 3'd4; end // P
            5'd16:   begin p.bits = 5'b01011; p.len = 3'd4; end // Q
            5'd17:   begin p.bits = 5'b00010; p.len = 3'd3; end // R
            5'd18:   begin p.bits = 5'b00000; p.len = 3'd3; end // S
            5'd19:   begin p.bits = 5'b00001; p.len = 3'd1; end // T
            5'd20:   begin p.bits = 5'b00100; p.len = 3'd3; end // U
            5'd21:   begin p.bits = 5'b01000; p.len = 3'd4; end // V
            5'd22:   begin p.bits = 5'b00110; p.len = 3'd3; end // W
            5'd23:   begin p.bits = 5'b01001; p.len = 3'd4; end // X
            5'd24:   begin p.bits = 5'b01101; p.len = 3'd4; end // Y
            5'd25:   begin p.bits = 5'b00011; p.len = 3'd4; end // Z
            default: begin p.bits = 5'b00000; p.len = 3'd0; p.known = 1'b0; end
        endcase
        return p;
    endfunction

    function automatic t_pattern digit_pattern(input logic [3:0] idx);
        t_pattern p;
        p.known = 1'b1;
        p.len   = 3'd5;
        case (idx)
            4'd0:    p.bits = 5'b11111;
            4'd1:    p.bits = 5'b11110;
            4'd2:    p.bits = 5'b11100;
            4'd3:    p.bits = 5'b11000;
            4'd4:    p.bits = 5'b10000;
            4'd5:    p.bits = 5'b00000;
            4'd6:    p.bits = 5'b00001;
            4'd7:    p.bits = 5'b00011;
            4'd8:    p.bits = 5'b00111;
            4'd9:    p.bits = 5'b01111;
            default: begin p.bits = 5'b00000; p.len = 3'd0; p.known = 1'b0; end
        endcase
        return p;
    endfunction

    // Upper and lower case letters and digits; anything else is unknown.
    function automatic t_pattern char_pattern(input logic [7:0] code);
        t_pattern p;
        p = '0;
        if (code inside {[8'h41:8'h5A]}) begin
            p = letter_pattern(5'(code - 8'h41));
        end else if (code inside {[8'h61:8'h7A]}) begin
            p = letter_pattern(5'(code - 8'h61));
        end else if (code inside {[8'h30:8'h39]}) begin
            p = digit_pattern(4'(code - 8'h30));
        end
        return p;
    endfunction

endpackage

// File: rtl/core/mbk_store.sv
module mbk_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbk_pkg::t_store_wr             i_wr,
    input  logic [mbk_pkg::AW-1:0]         i_rd_addr_a,
    input  logic [mbk_pkg::AW-1:0]         i_rd_addr_b,
    output logic [7:0]                     o_rd_data_a,
    output logic [7:0]                     o_rd_data_b
);

    logic [7:0]                      r_mem [mbk_pkg::STORE_DEPTH];
    logic [mbk_pkg::STORE_DEPTH-1:0] r_valid;
    logic [7:0]                      r_rd_a;
    logic [7:0]                      r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Entries never written read as zero; same-cycle writes are forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_a  <= '0;
            r_rd_b  <= '0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_wr.en && i_wr.addr == i_rd_addr_a) begin
                r_rd_a <= i_wr.data;
            end else if (r_valid[i_rd_addr_a]) begin
                r_rd_a <= r_mem[i_rd_addr_a];
            end else begin
                r_rd_a <= '0;
            end
            if (i_wr.en && i_wr.addr == i_rd_addr_b) begin
                r_rd_b <= i_wr.data;
            end else if (r_valid[i_rd_addr_b]) begin
                r_rd_b <= r_mem[i_rd_addr_b];
            end else begin
                r_rd_b <= '0;
            end
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// File: rtl/core/morse_beacon_keyer.sv
// A result beat is registered and shown in the cycle after its input beat is taken.
// Throughput: one input beat per cycle; the input stalls only while a shown result
//   is itself stalled.
// Reset (i_rst_n low, synchronous): keyer idle, SOS off, lamps off, read
//   position 0; the message store reads as empty through per-entry valid bits.
module morse_beacon_keyer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mbk_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mbk_pkg::t_out_beat o_out_beat
);

    // Keyer modes.
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_DOT      = 3'd1;
    localparam logic [2:0] MODE_DASH     = 3'd2;
    localparam logic [2:0] MODE_ELEM_GAP = 3'd3;
    localparam logic [2:0] MODE_CHAR_GAP = 3'd4;
    localparam logic [2:0] MODE_WORD_GAP = 3'd5;

    // Lamp bits.
    localparam logic [2:0] LAMP_DOT  = 3'b001;
    localparam logic [2:0] LAMP_DASH = 3'b010;
    localparam logic [2:0] LAMP_SOS  = 3'b100;

    // Tick counts for each element and gap.
    localparam logic [2:0] DOT_TICKS  = 3'd1;
    localparam logic [2:0] DASH_TICKS = 3'd3;
    localparam logic [2:0] ELEM_TICKS = 3'd1;
    localparam logic [2:0] CHAR_TICKS = 3'd3;
    localparam logic [2:0] WORD_TICKS = 3'd6;

    // SOS blink: toggle every SOS_PERIOD ticks, end after SOS_LENGTH.
    localparam logic [2:0] SOS_PERIOD = 3'd5;
    localparam logic [6:0] SOS_LENGTH = 7'd100;

    localparam int AW = mbk_pkg::AW;

    logic [2:0]    r_mode,     n_mode;
    logic [2:0]    r_gap,      n_gap;
    logic [4:0]    r_bits,     n_bits;
    logic [2:0]    r_len,      n_len;
    logic [2:0]    r_eidx,     n_eidx;
    logic [AW-1:0] r_pos,      n_pos;
    logic          r_sos_flag, n_sos_flag;
    logic [6:0]    r_sos_cnt,  n_sos_cnt;
    logic [2:0]    r_sos_ph,   n_sos_ph;
    logic [2:0]    r_lamps,    n_lamps;
    logic          r_nxt_end;
    logic          r_out_valid;
    mbk_pkg::t_out_beat r_out_beat;

    logic               accept;
    logic               do_start;
    logic               do_finish;
    logic [7:0]         cur_char;
    logic [7:0]         nxt_char;
    logic [7:0]         bits_ext;
    logic [2:0]         eidx_inc;
    logic [6:0]         sos_cnt_inc;
    mbk_pkg::t_pattern  cur_pat;
    mbk_pkg::t_store_wr store_wr;

    // The output register parts the two sides: a new beat is taken whenever
    // the result slot is empty or being drained this cycle.
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    assign store_wr.en   = accept && i_in_beat.command == mbk_pkg::CMD_WRITE
                           && int'(i_in_beat.store_index) < mbk_pkg::STORE_DEPTH;
    assign store_wr.addr = AW'(i_in_beat.store_index);
    assign store_wr.data = i_in_beat.char_code;

    // Port a reads the character at the read position, port b the one after.
    // Both are addressed by next position, so the registered data always
    // lines up with r_pos.
    mbk_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (store_wr),
        .i_rd_addr_a (n_pos),
        .i_rd_addr_b (n_pos + AW'(1)),
        .o_rd_data_a (cur_char),
        .o_rd_data_b (nxt_char)
    );

    assign cur_pat     = mbk_pkg::char_pattern(cur_char);
    assign bits_ext    = {3'b000, r_bits};
    assign eidx_inc    = r_eidx + 3'd1;
    assign sos_cnt_inc = r_sos_cnt + 7'd1;

    always_comb begin
        n_mode     = r_mode;
        n_gap      = r_gap;
        n_bits     = r_bits;
        n_len      = r_len;
        n_eidx     = r_eidx;
        n_pos      = r_pos;
        n_sos_flag = r_sos_flag;
        n_sos_cnt  = r_sos_cnt;
        n_sos_ph   = r_sos_ph;
        n_lamps    = r_lamps;
        do_start   = 1'b0;
        do_finish  = 1'b0;

        if (accept) begin
            case (i_in_beat.command)
                mbk_pkg::CMD_TICK: begin
                    if (i_in_beat.transmit_enable && r_sos_flag) begin
                        // SOS owns the tick; first tick clears dot/dash.
                        if (r_sos_cnt == 7'd0) begin
                            n_lamps = LAMP_SOS;
                        end
                        n_sos_cnt = sos_cnt_inc;
                        if (r_sos_ph == SOS_PERIOD - 3'd1) begin
                            n_sos_ph = 3'd0;
                            n_lamps  = n_lamps ^ LAMP_SOS;
                        end else begin
                            n_sos_ph = r_sos_ph + 3'd1;
                        end
                        if (sos_cnt_inc >= SOS_LENGTH) begin
                            n_sos_cnt  = 7'd0;
                            n_sos_ph   = 3'd0;
                            n_sos_flag = 1'b0;
                            n_lamps    = n_lamps & ~LAMP_SOS;
                        end
                    end else if (i_in_beat.transmit_enable) begin
                        case (r_mode)
                            MODE_IDLE: begin
                                do_start = 1'b1;
                            end
                            MODE_DOT, MODE_DASH: begin
                                if (r_gap < ((r_mode == MODE_DOT) ? DOT_TICKS
                                                                  : DASH_TICKS)) begin
                                    n_lamps = r_lamps | ((r_mode == MODE_DOT) ? LAMP_DOT
                                                                              : LAMP_DASH);
                                    n_gap   = r_gap + 3'd1;
                                end else begin
                                    n_gap  = 3'd0;
                                    n_eidx = eidx_inc;
                                    if (eidx_inc >= r_len) begin
                                        do_finish = 1'b1;
                                    end else begin
                                        n_mode = MODE_ELEM_GAP;
                                    end
                                end
                            end
                            MODE_ELEM_GAP, MODE_CHAR_GAP, MODE_WORD_GAP: begin
                                // Gaps darken the element lamps, then move on.
                                if (r_gap < ((r_mode == MODE_ELEM_GAP) ? ELEM_TICKS :
                                             (r_mode == MODE_CHAR_GAP) ? CHAR_TICKS :
                                                                         WORD_TICKS)) begin
                                    n_lamps = r_lamps & ~(LAMP_DOT | LAMP_DASH);
                                    n_gap   = r_gap + 3'd1;
                                end else begin
                                    n_gap = 3'd0;
                                    if (r_mode == MODE_ELEM_GAP) begin
                                        n_mode = bits_ext[r_eidx] ? MODE_DASH : MODE_DOT;
                                    end else if (r_mode == MODE_CHAR_GAP) begin
                                        do_start = 1'b1;
                                    end else begin
                                        n_mode = MODE_IDLE;
                                        n_pos  = '0;
                                    end
                                end
                            end
                            default: begin
                                n_mode = MODE_IDLE;
                                n_gap  = 3'd0;
                            end
                        endcase
                    end
                end
                mbk_pkg::CMD_WRITE: begin
                    // store write only
                end
                mbk_pkg::CMD_SOS: begin
                    n_sos_flag = 1'b1;
                end
                default: begin
                    // no operation
                end
            endcase
        end

        // Load the character at the read position.
        if (do_start) begin
            n_gap = 3'd0;
            if (cur_char == 8'd0) begin
                // empty message: park at the start
                n_pos  = '0;
                n_mode = MODE_IDLE;
            end else if (!cur_pat.known) begin
                do_finish = 1'b1;
            end else begin
                n_bits = cur_pat.bits;
                n_len  = cur_pat.len;
                n_eidx = 3'd0;
                n_mode = cur_pat.bits[0] ? MODE_DASH : MODE_DOT;
            end
        end

        // Character done: step on, or word gap at message or store end.
        if (do_finish) begin
            n_gap = 3'd0;
            if (r_nxt_end || nxt_char == 8'd0) begin
                n_pos  = '0;
                n_mode = MODE_WORD_GAP;
            end else begin
                n_pos  = r_pos + AW'(1);
                n_mode = MODE_CHAR_GAP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_gap       <= 3'd0;
            r_bits      <= 5'd0;
            r_len       <= 3'd0;
            r_eidx      <= 3'd0;
            r_pos       <= '0;
            r_sos_flag  <= 1'b0;
            r_sos_cnt   <= 7'd0;
            r_sos_ph    <= 3'd0;
            r_lamps     <= 3'd0;
            r_nxt_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_gap       <= n_gap;
            r_bits      <= n_bits;
            r_len       <= n_len;
            r_eidx      <= n_eidx;
            r_pos       <= n_pos;
            r_sos_flag  <= n_sos_flag;
            r_sos_cnt   <= n_sos_cnt;
            r_sos_ph    <= n_sos_ph;
            r_lamps     <= n_lamps;
            // The position after the last store entry counts as message end.
            r_nxt_end   <= (int'(n_pos) + 1 >= mbk_pkg::STORE_DEPTH);
            r_out_valid <= accept || (r_out_valid && i_out_stall);
        end
    end

    // Result beat: levels after this item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_beat.dot_lamp      <= n_lamps[0];
            r_out_beat.dash_lamp     <= n_lamps[1];
            r_out_beat.sos_lamp      <= n_lamps[2];
            r_out_beat.sos_active    <= n_sos_flag;
            r_out_beat.read_position <= 7'(n_pos);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// File: rtl/core/mbk_checker.sv
`include "morse_beacon_keyer_assert.svh"

module mbk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mbk_pkg::t_in_beat  i_in_beat,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mbk_pkg::t_out_beat o_out_beat
);

    `MBK_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    `MBK_ASSERT_NEXT(a_beat_out, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid)

    `MBK_ASSERT_NOW(a_sos_lamp_active, i_clk, i_rst_n, o_out_valid && o_out_beat.sos_lamp, o_out_beat.sos_active)

    `MBK_ASSERT_NOW(a_sos_lamp_alone, i_clk, i_rst_n, o_out_valid && o_out_beat.sos_lamp, !o_out_beat.dot_lamp && !o_out_beat.dash_lamp)

    `MBK_ASSERT_NOW(a_dot_dash_excl, i_clk, i_rst_n, o_out_valid, !(o_out_beat.dot_lamp && o_out_beat.dash_lamp))

endmodule

bind morse_beacon_keyer mbk_checker u_mbk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BEATS   = 950;

    // Keyer phases as the predictor tracks them.
    typedef enum logic [2:0] {
        KEY_IDLE,
        KEY_DOT,
        KEY_DASH,
        KEY_ELEM_GAP,
        KEY_CHAR_GAP,
        KEY_WORD_GAP
    } t_keyer_mode;

    // Predicts the lamp/position beat for every accepted input beat and
    // checks the output beats against those predictions in order.
    class t_keyer_scoreboard;
        logic [7:0]         msg_store [mbk_pkg::STORE_DEPTH];
        t_keyer_mode        mode;
        int                 gap_cnt;
        int                 elem_idx;
        int                 pat_len;
        int                 read_pos;
        int                 sos_cnt;
        logic [4:0]         pat_bits;
        bit                 sos_on;
        bit                 dot_on;
        bit                 dash_on;
        bit                 sos_lit;
        mbk_pkg::t_out_beat expected_q [$];
        int                 n_checked;
        int                 n_errors;

        string letter_code [26] = '{
            ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
            ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
            "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
        };
        string digit_code [10] = '{
            "-----", ".----", "..---", "...--", "....-",
            ".....", "-....", "--...", "---..", "----."
        };

        function new();
            foreach (msg_store[i]) msg_store[i] = 8'h00;
            mode      = KEY_IDLE;
            gap_cnt   = 0;
            elem_idx  = 0;
            pat_len   = 0;
            read_pos  = 0;
            sos_cnt   = 0;
            pat_bits  = '0;
            sos_on    = 1'b0;
            dot_on    = 1'b0;
            dash_on   = 1'b0;
            sos_lit   = 1'b0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Bit i of bits set means element i is a dash.
        function bit morse_lookup(input logic [7:0] code, output logic [4:0] bits,
                                  output int len);
            string s;
            bits = '0;
            len  = 0;
            if (code >= 8'h41 && code <= 8'h5A) begin
                s = letter_code[code - 8'h41];
            end else if (code >= 8'h61 && code <= 8'h7A) begin
                s = letter_code[code - 8'h61];
            end else if (code >= 8'h30 && code <= 8'h39) begin
                s = digit_code[code - 8'h30];
            end else begin
                return 1'b0;
            end
            len = s.len();
            for (int i = 0; i < len; i++) begin
                if (s.getc(i) == "-") bits[i] = 1'b1;
            end
            return 1'b1;
        endfunction

        function void next_element();
            mode = pat_bits[elem_idx] ? KEY_DASH : KEY_DOT;
        endfunction

        // Character done: next position, or word gap at end of text/store.
        function void end_char();
            gap_cnt = 0;
            if (read_pos + 1 >= mbk_pkg::STORE_DEPTH
                || msg_store[read_pos + 1] == 8'h00) begin
                read_pos = 0;
                mode     = KEY_WORD_GAP;
            end else begin
                read_pos++;
                mode = KEY_CHAR_GAP;
            end
        endfunction

        function void begin_char();
            logic [7:0] code;
            logic [4:0] bits;
            int         len;
            gap_cnt = 0;
            code    = msg_store[read_pos];
            if (code == 8'h00) begin
                read_pos = 0;
                mode     = KEY_IDLE;
            end else if (!morse_lookup(code, bits, len)) begin
                end_char();
            end else begin
                pat_bits = bits;
                pat_len  = len;
                elem_idx = 0;
                next_element();
            end
        endfunction

        function void element_step(input int limit, input bit dash);
            if (gap_cnt < limit) begin
                if (dash) dash_on = 1'b1;
                else      dot_on  = 1'b1;
                gap_cnt++;
            end else begin
                gap_cnt = 0;
                elem_idx++;
                if (elem_idx >= pat_len) end_char();
                else                     mode = KEY_ELEM_GAP;
            end
        endfunction

        // Gap ticks clear the keying lamps; returns 1 on the tick that moves on.
        function bit gap_step(input int limit);
            if (gap_cnt < limit) begin
                dot_on  = 1'b0;
                dash_on = 1'b0;
                gap_cnt++;
                return 1'b0;
            end
            gap_cnt = 0;
            return 1'b1;
        endfunction

        function void keyer_step();
            case (mode)
                KEY_IDLE:     begin_char();
                KEY_DOT:      element_step(1, 1'b0);
                KEY_DASH:     element_step(3, 1'b1);
                KEY_ELEM_GAP: if (gap_step(1)) next_element();
                KEY_CHAR_GAP: if (gap_step(3)) begin_char();
                KEY_WORD_GAP: begin
                    if (gap_step(6)) begin
                        mode     = KEY_IDLE;
                        read_pos = 0;
                    end
                end
                default: begin
                    mode    = KEY_IDLE;
                    gap_cnt = 0;
                end
            endcase
        endfunction

        // SOS blink: first tick clears keying lamps, toggle every 5, done at 100.
        function void sos_step();
            if (sos_cnt == 0) begin
                dot_on  = 1'b0;
                dash_on = 1'b0;
                sos_lit = 1'b1;
            end
            sos_cnt++;
            if (sos_cnt % 5 == 0) sos_lit = !sos_lit;
            if (sos_cnt >= 100) begin
                sos_cnt = 0;
                sos_on  = 1'b0;
                sos_lit = 1'b0;
            end
        endfunction

        function void note_beat(input mbk_pkg::t_in_beat b);
            mbk_pkg::t_out_beat want;
            case (b.command)
                mbk_pkg::CMD_TICK: begin
                    if (b.transmit_enable) begin
                        if (sos_on) sos_step();
                        else        keyer_step();
                    end
                end
                mbk_pkg::CMD_WRITE: begin
                    if (b.store_index < mbk_pkg::STORE_DEPTH)
                        msg_store[b.store_index] = b.char_code;
                end
                mbk_pkg::CMD_SOS: sos_on = 1'b1;
                default:          ;
            endcase
            want.dot_lamp      = dot_on;
            want.dash_lamp     = dash_on;
            want.sos_lamp      = sos_lit;
            want.sos_active    = sos_on;
            want.read_position = 7'(read_pos);
            expected_q.push_back(want);
        endfunction

        function void compare_field(input string name, input logic [6:0] want,
                                    input logic [6:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                n_errors++;
            end
        endfunction

        function void check_beat(input mbk_pkg::t_out_beat got);
            mbk_pkg::t_out_beat want;
            if (expected_q.size() == 0) begin
                $display("%0t: output beat with none expected, expected nothing, got %h",
                         $time, got);
                n_errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            compare_field("dot_lamp", want.dot_lamp, got.dot_lamp);
            compare_field("dash_lamp", want.dash_lamp, got.dash_lamp);
            compare_field("sos_lamp", want.sos_lamp, got.sos_lamp);
            compare_field("sos_active", want.sos_active, got.sos_active);
            compare_field("read_position", want.read_position, got.read_position);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and the block under test
    // ------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    mbk_pkg::t_in_beat  i_in_beat   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    mbk_pkg::t_out_beat o_out_beat;

    t_keyer_scoreboard sb = new();

    // Random idling: off for whole phases when quiet is set.
    bit quiet       = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int n_beats     = 0;
    int n_sos       = 0;

    always #5 i_clk = ~i_clk;

    morse_beacon_keyer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    // ------------------------------------------------------------------
    // Output side: check each taken beat, then pick the next stall level.
    // Values read here are the ones that were present at the clock edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        int r;
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_beat(o_out_beat);
        if (quiet) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                i_out_stall <= 1'b0;
            end else begin
                // mostly short stalls, now and then a long one
                stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                i_out_stall <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles in a row without any beat moving.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat moved for %0d cycles", $time, idle_cycles);
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic mbk_pkg::t_in_beat beat_of(input logic [1:0] cmd, input logic en,
                                                  input logic [6:0] idx,
                                                  input logic [7:0] code);
        mbk_pkg::t_in_beat b;
        b.command         = cmd;
        b.transmit_enable = en;
        b.store_index     = idx;
        b.char_code       = code;
        return b;
    endfunction

    // Called at a clock edge; returns at the edge where the beat is taken.
    // Valid gets at most one update per edge, so back-to-back beats keep it high.
    task automatic send_beat(input mbk_pkg::t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(b);
        if (!(b.command == mbk_pkg::CMD_NOP
              || (b.command == mbk_pkg::CMD_TICK && !b.transmit_enable)))
            n_beats++;
    endtask

    task automatic tick(input logic en);
        send_beat(beat_of(mbk_pkg::CMD_TICK, en, 7'($urandom_range(0, 127)),
                          8'($urandom_range(0, 255))));
    endtask

    task automatic write_char(input logic [6:0] idx, input logic [7:0] code);
        send_beat(beat_of(mbk_pkg::CMD_WRITE, 1'($urandom_range(0, 1)), idx, code));
    endtask

    task automatic raise_sos();
        n_sos++;
        send_beat(beat_of(mbk_pkg::CMD_SOS, 1'($urandom_range(0, 1)),
                          7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))));
    endtask

    // Sender holds off until every predicted beat has come back.
    task automatic drain_pause();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Nonzero codes with no Morse pattern.
    function automatic logic [7:0] unknown_char();
        case ($urandom_range(0, 4))
            0:       return 8'h2E;                        // '.'
            1:       return 8'h20;                        // space
            2:       return 8'h23;                        // '#'
            3:       return 8'($urandom_range(1, 8'h2F));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    function automatic logic [7:0] message_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'(8'h41 + $urandom_range(0, 25));   // A-Z
        if (r < 60) return 8'(8'h61 + $urandom_range(0, 25));   // a-z
        if (r < 85) return 8'(8'h30 + $urandom_range(0, 9));    // 0-9
        return unknown_char();
    endfunction

    // Short text from position 0, then mostly enabled ticks with some noise:
    // idle beats, stray writes (also into the text being sent), SOS requests.
    task automatic message_phase();
        int len;
        int r;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) write_char(7'(i), message_char());
        write_char(7'(len), 8'h00);
        repeat ($urandom_range(40, 140)) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                tick(1'b1);
            else if (r < 86)
                tick(1'b0);
            else if (r < 90)
                send_beat(beat_of(mbk_pkg::CMD_NOP, 1'($urandom_range(0, 1)),
                                  7'($urandom_range(0, 127)), 8'($urandom_range(0, 255))));
            else if (r < 94)
                write_char(7'($urandom_range(len + 1, 127)), 8'($urandom_range(0, 255)));
            else if (r < 96)
                raise_sos();
            else
                write_char(7'($urandom_range(0, len - 1)), message_char());
        end
    endtask

    task automatic sos_phase();
        raise_sos();
        repeat ($urandom_range(105, 125)) begin
            case ($urandom_range(0, 19))
                0:       raise_sos();   // no effect while running
                1:       tick(1'b0);    // blink frozen
                default: tick(1'b1);
            endcase
        end
    endtask

    // Position 0 cleared: keyer falls back to idle at the next character.
    task automatic empty_phase();
        write_char(7'd0, 8'h00);
        repeat ($urandom_range(8, 20)) tick(1'b1);
    endtask

    // Whole store nonzero, so the keyer walks off the last position.
    task automatic full_store_phase();
        for (int i = 0; i < mbk_pkg::STORE_DEPTH; i++)
            write_char(7'(i), ($urandom_range(0, 31) == 0) ? message_char() : unknown_char());
        // ~4 ticks per skipped char, a few sent ones, plus room for a running SOS
        repeat (5 * mbk_pkg::STORE_DEPTH + 120) tick(1'b1);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, ignored beats, extreme fields, a short text
        // with a dash, an unknown char and a digit, SOS start and a repeat.
        tick(1'b1);
        send_beat(beat_of(mbk_pkg::CMD_NOP, 1'b1, 7'd127, 8'hFF));
        tick(1'b0);
        write_char(7'd127, 8'hFF);
        write_char(7'd0, 8'h54);    // 'T'
        write_char(7'd1, 8'h2E);    // '.', skipped
        write_char(7'd2, 8'h30);    // '0'
        write_char(7'd3, 8'h65);    // 'e'
        write_char(7'd4, 8'h00);
        repeat (12) tick(1'b1);
        raise_sos();
        tick(1'b1);
        raise_sos();
        tick(1'b0);

        full_store_phase();
        drain_pause();

        while (n_beats < RANDOM_BEATS) begin
            quiet <= ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0, 1, 2:    sos_phase();
                3, 4:       empty_phase();
                default:    message_phase();
            endcase
            if ($urandom_range(0, 2) == 0) drain_pause();
        end
        quiet <= 1'b0;

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Run: %0d working beats, %0d SOS requests, %0d output beats checked,",
                 n_beats, n_sos, sb.n_checked);
        $display("full-store wrap, all keyer phases, stalls on both sides; %0d errors.",
                 sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mbk_pkg.sv
rtl/core/mbk_store.sv
rtl/core/morse_beacon_keyer.sv
rtl/core/mbk_checker.sv
test/testbench.sv
